// ===== hw/rtl/cfcc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the circle fit coverage check unit.
// Used by the controller, the CORDIC unit, the datapath and the top level.
package cfcc_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 4;

    localparam logic [13:0] ATAN_TAB [CORDIC_STEPS] = '{
        14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
        14'd41,   14'd20,   14'd10,   14'd5,    14'd3,   14'd1,   14'd1,   14'd0
    };

    localparam logic [16:0] ANG_OCTANT  = 17'd8192;
    localparam logic [16:0] ANG_QUARTER = 17'd16384;
    localparam logic [16:0] ANG_HALF    = 17'd32768;
    localparam logic [16:0] ANG_FULL    = 17'd65536;

    localparam int RAD_W   = 23;
    localparam int PROP_W  = 16;
    localparam int INNER_W = 16;
    localparam int OCC_W   = 6;
    localparam int SEC_W   = 6;
    localparam int N_W     = 7;
    localparam int T_W     = 39;
    localparam int TT_W    = 78;
    localparam int R2_W    = 48;
    localparam int D_W     = 64;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RING_WIDTH  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_PROP  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_LIMIT = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SECTORS = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_CNT  = 4'd7;

    localparam logic [SEC_W-1:0] SECTOR_CNT_RESET = 6'd16;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_T,
        MUL_DX,
        MUL_DY,
        MUL_RLO,
        MUL_RHI,
        MUL_THH,
        MUL_THL,
        MUL_TLL
    } t_mul_op;

    typedef enum logic [1:0] {
        VERDICT_PASS     = 2'd0,
        VERDICT_INNER    = 2'd1,
        VERDICT_COVERAGE = 2'd2
    } t_verdict;

    typedef struct packed {
        logic              load;
        logic              prep;
        logic              cordic_en;
        logic [STEP_W-1:0] step;
        t_mul_op           mul_op;
        logic              angle;
        logic              update;
        logic              emit;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_stat;

endpackage

// ===== hw/rtl/cfcc_pt_if.sv =====
`timescale 1ns / 1ps
// Point channel: valid/ready handshake carrying one 2D point.
// Standalone; no package dependency.
interface cfcc_pt_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    output ready);
endinterface

// ===== hw/rtl/cfcc_res_if.sv =====
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one section verdict.
// Standalone; no package dependency.
interface cfcc_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] inner_points;
    logic [5:0]  occupied_sectors;
    logic [1:0]  verdict;

    modport source (output valid, output inner_points, output occupied_sectors,
                    output verdict, input ready);
    modport sink   (input valid, input inner_points, input occupied_sectors,
                    input verdict, output ready);
endinterface

// ===== hw/rtl/cfcc_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for one point: load, prepare, CORDIC/multiply run, angle, update, emit.
// Depends on cfcc_pkg for the command and status structs.
module cfcc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  cfcc_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output cfcc_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_RUN,
        S_ANGLE,
        S_DECIDE,
        S_EMIT
    } t_state;

    t_state                      r_state, n_state;
    logic [cfcc_pkg::STEP_W-1:0] r_cnt, n_cnt;
    logic                        r_in_ready;
    cfcc_pkg::t_cmd              w_cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        w_cmd   = '0;
        w_cmd.mul_op = cfcc_pkg::MUL_NONE;
        unique case (r_state)
            S_IDLE: begin
                w_cmd.load = i_in_valid && r_in_ready;
                if (i_in_valid && r_in_ready) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                w_cmd.prep = 1'b1;
                n_cnt      = '0;
                n_state    = S_RUN;
            end
            S_RUN: begin
                w_cmd.cordic_en = 1'b1;
                w_cmd.step      = r_cnt;
                unique case (r_cnt)
                    4'd0:    w_cmd.mul_op = cfcc_pkg::MUL_T;
                    4'd1:    w_cmd.mul_op = cfcc_pkg::MUL_DX;
                    4'd2:    w_cmd.mul_op = cfcc_pkg::MUL_DY;
                    4'd3:    w_cmd.mul_op = cfcc_pkg::MUL_RLO;
                    4'd4:    w_cmd.mul_op = cfcc_pkg::MUL_RHI;
                    4'd5:    w_cmd.mul_op = cfcc_pkg::MUL_THH;
                    4'd6:    w_cmd.mul_op = cfcc_pkg::MUL_THL;
                    4'd7:    w_cmd.mul_op = cfcc_pkg::MUL_TLL;
                    default: w_cmd.mul_op = cfcc_pkg::MUL_NONE;
                endcase
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 4'(cfcc_pkg::CORDIC_STEPS - 1)) begin
                    n_state = S_ANGLE;
                end
            end
            S_ANGLE: begin
                w_cmd.angle = 1'b1;
                n_state     = S_DECIDE;
            end
            S_DECIDE: begin
                w_cmd.update = 1'b1;
                n_state      = i_stat.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                w_cmd.emit = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd      = w_cmd;

endmodule

// ===== hw/rtl/cfcc_cordic.sv =====
`timescale 1ns / 1ps
// Vectoring CORDIC, one iteration per enabled cycle, accumulating a binary angle.
// Depends on cfcc_pkg for the arctangent table.
module cfcc_cordic #(
    parameter int CW = 35
) (
    input  logic                        i_clk,
    input  logic                        i_init,
    input  logic [CW-1:0]               i_x0,
    input  logic [CW-1:0]               i_y0,
    input  logic                        i_step_en,
    input  logic [cfcc_pkg::STEP_W-1:0] i_idx,
    output logic signed [15:0]          o_acc
);

    logic signed [CW-1:0] r_x, r_y;
    logic signed [15:0]   r_acc;
    logic signed [CW-1:0] w_xs, w_ys;
    logic signed [15:0]   w_tab;

    assign w_xs  = r_x >>> i_idx;
    assign w_ys  = r_y >>> i_idx;
    assign w_tab = signed'({2'b00, cfcc_pkg::ATAN_TAB[i_idx]});

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_x   <= signed'(i_x0);
            r_y   <= signed'(i_y0);
            r_acc <= '0;
        end else if (i_step_en) begin
            if (r_y > 0) begin
                r_x   <= r_x + w_ys;
                r_y   <= r_y - w_xs;
                r_acc <= r_acc + w_tab;
            end else if (r_y < 0) begin
                r_x   <= r_x - w_ys;
                r_y   <= r_y + w_xs;
                r_acc <= r_acc - w_tab;
            end
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== hw/rtl/cfcc_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: configuration registers, shared multiplier, CORDIC, counters, result register.
// Depends on cfcc_pkg and cfcc_cordic.
module cfcc_datapath #(
    parameter int MAX_SECTORS = 32,
    parameter int COORD_BITS  = 24,
    parameter int CFG_W       = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cfcc_pkg::t_cmd                 i_cmd,
    output cfcc_pkg::t_stat                o_stat,
    input  logic                           i_cfg_we,
    input  logic [cfcc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]               i_cfg_data,
    input  logic [COORD_BITS-1:0]          i_px,
    input  logic [COORD_BITS-1:0]          i_py,
    input  logic                           i_last,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [cfcc_pkg::INNER_W-1:0]   o_inner,
    output logic [cfcc_pkg::OCC_W-1:0]     o_occ,
    output logic [1:0]                     o_verdict
);

    localparam int DXW = COORD_BITS + 1;
    localparam int MW  = (COORD_BITS + 1 > 24) ? COORD_BITS + 1 : 24;
    localparam int PW  = 2 * MW;
    localparam int SW  = (PW + 1 > 65) ? PW + 1 : 65;
    localparam int CW  = COORD_BITS + 11;
    localparam int SIW = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;

    // configuration
    logic [COORD_BITS-1:0]         r_cx, r_cy;
    logic [cfcc_pkg::RAD_W-1:0]    r_rad, r_ring;
    logic [cfcc_pkg::PROP_W-1:0]   r_prop;
    logic [cfcc_pkg::INNER_W-1:0]  r_ilim;
    logic [cfcc_pkg::SEC_W-1:0]    r_min_sec, r_sec_cnt;

    // per-point working registers
    logic [DXW-1:0]                r_dx, r_dy;
    logic                          r_last;
    logic [MW-1:0]                 r_adx, r_ady;
    logic                          r_swapped, r_xneg, r_yneg;
    logic [23:0]                   r_rlo_abs, r_rhi;
    logic [PW-1:0]                 r_prod;
    cfcc_pkg::t_mul_op             r_prod_op;
    logic [cfcc_pkg::T_W-1:0]      r_t;
    logic [cfcc_pkg::TT_W-1:0]     r_tt;
    logic [SW-1:0]                 r_dsum;
    logic [cfcc_pkg::R2_W-1:0]     r_rmin2, r_rmax2;
    logic [15:0]                   r_angle;

    // section state and result
    logic [cfcc_pkg::INNER_W-1:0]  r_inner;
    logic [MAX_SECTORS-1:0]        r_marks;
    logic [cfcc_pkg::OCC_W-1:0]    r_occ;
    logic                          r_out_valid;
    logic [cfcc_pkg::INNER_W-1:0]  r_out_inner;
    logic [cfcc_pkg::OCC_W-1:0]    r_out_occ;
    cfcc_pkg::t_verdict            r_out_verdict;

    logic [DXW-1:0]                w_adx, w_ady;
    logic                          w_swap;
    logic [CW-1:0]                 w_x0, w_y0;
    logic [23:0]                   w_rlo;
    logic [MW-1:0]                 w_ma, w_mb;
    logic signed [15:0]            w_acc;
    logic [13:0]                   w_acc_c;
    logic [14:0]                   w_a;
    logic [16:0]                   w_ang;
    logic [cfcc_pkg::D_W-1:0]      w_d;
    logic                          w_ring_hit, w_inner_hit;
    logic [cfcc_pkg::N_W-1:0]      w_n, w_s, w_s_c;
    logic [22:0]                   w_sp;
    logic [SIW-1:0]                w_idx;
    cfcc_pkg::t_verdict            w_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx      <= '0;
            r_cy      <= '0;
            r_rad     <= '0;
            r_ring    <= '0;
            r_prop    <= '0;
            r_ilim    <= '0;
            r_min_sec <= '0;
            r_sec_cnt <= cfcc_pkg::SECTOR_CNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cfcc_pkg::REG_CENTER_X:    r_cx      <= i_cfg_data[COORD_BITS-1:0];
                cfcc_pkg::REG_CENTER_Y:    r_cy      <= i_cfg_data[COORD_BITS-1:0];
                cfcc_pkg::REG_RADIUS:      r_rad     <= i_cfg_data[cfcc_pkg::RAD_W-1:0];
                cfcc_pkg::REG_RING_WIDTH:  r_ring    <= i_cfg_data[cfcc_pkg::RAD_W-1:0];
                cfcc_pkg::REG_INNER_PROP:  r_prop    <= i_cfg_data[cfcc_pkg::PROP_W-1:0];
                cfcc_pkg::REG_INNER_LIMIT: r_ilim    <= i_cfg_data[cfcc_pkg::INNER_W-1:0];
                cfcc_pkg::REG_MIN_SECTORS: r_min_sec <= i_cfg_data[cfcc_pkg::SEC_W-1:0];
                cfcc_pkg::REG_SECTOR_CNT:  r_sec_cnt <= i_cfg_data[cfcc_pkg::SEC_W-1:0];
                default: ;
            endcase
        end
    end

    // prepare: magnitudes, octant fold, annulus radii
    assign w_adx  = r_dx[DXW-1] ? (~r_dx + 1'b1) : r_dx;
    assign w_ady  = r_dy[DXW-1] ? (~r_dy + 1'b1) : r_dy;
    assign w_swap = (w_ady > w_adx);
    assign w_x0   = CW'({(w_swap ? w_ady : w_adx), 8'h00});
    assign w_y0   = CW'({(w_swap ? w_adx : w_ady), 8'h00});
    assign w_rlo  = {1'b0, r_rad} - {1'b0, r_ring};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx   <= {i_px[COORD_BITS-1], i_px} - {r_cx[COORD_BITS-1], r_cx};
            r_dy   <= {i_py[COORD_BITS-1], i_py} - {r_cy[COORD_BITS-1], r_cy};
            r_last <= i_last;
        end
        if (i_cmd.prep) begin
            r_adx     <= MW'(w_adx);
            r_ady     <= MW'(w_ady);
            r_swapped <= w_swap;
            r_xneg    <= r_dx[DXW-1];
            r_yneg    <= r_dy[DXW-1];
            r_rlo_abs <= w_rlo[23] ? (~w_rlo + 1'b1) : w_rlo;
            r_rhi     <= {1'b0, r_rad} + {1'b0, r_ring};
        end
    end

    cfcc_cordic #(
        .CW (CW)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_init    (i_cmd.prep),
        .i_x0      (w_x0),
        .i_y0      (w_y0),
        .i_step_en (i_cmd.cordic_en),
        .i_idx     (i_cmd.step),
        .o_acc     (w_acc)
    );

    // shared multiplier: operand select, registered product, absorb next cycle
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_cmd.mul_op)
            cfcc_pkg::MUL_T: begin
                w_ma = MW'(r_rad);
                w_mb = MW'(r_prop);
            end
            cfcc_pkg::MUL_DX: begin
                w_ma = r_adx;
                w_mb = r_adx;
            end
            cfcc_pkg::MUL_DY: begin
                w_ma = r_ady;
                w_mb = r_ady;
            end
            cfcc_pkg::MUL_RLO: begin
                w_ma = MW'(r_rlo_abs);
                w_mb = MW'(r_rlo_abs);
            end
            cfcc_pkg::MUL_RHI: begin
                w_ma = MW'(r_rhi);
                w_mb = MW'(r_rhi);
            end
            cfcc_pkg::MUL_THH: begin
                w_ma = MW'(r_t[38:20]);
                w_mb = MW'(r_t[38:20]);
            end
            cfcc_pkg::MUL_THL: begin
                w_ma = MW'(r_t[38:20]);
                w_mb = MW'(r_t[19:0]);
            end
            cfcc_pkg::MUL_TLL: begin
                w_ma = MW'(r_t[19:0]);
                w_mb = MW'(r_t[19:0]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        case (r_prod_op)
            cfcc_pkg::MUL_T:   r_t     <= r_prod[38:0];
            cfcc_pkg::MUL_DX:  r_dsum  <= SW'(r_prod);
            cfcc_pkg::MUL_DY:  r_dsum  <= r_dsum + SW'(r_prod);
            cfcc_pkg::MUL_RLO: r_rmin2 <= r_prod[47:0];
            cfcc_pkg::MUL_RHI: r_rmax2 <= r_prod[47:0];
            cfcc_pkg::MUL_THH: r_tt    <= {r_prod[37:0], 40'd0};
            cfcc_pkg::MUL_THL: r_tt    <= r_tt + {18'd0, r_prod[38:0], 21'd0};
            cfcc_pkg::MUL_TLL: r_tt    <= r_tt + {38'd0, r_prod[39:0]};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_op <= cfcc_pkg::MUL_NONE;
        end else begin
            r_prod_op <= i_cmd.mul_op;
        end
    end

    // angle unfold
    assign w_acc_c = w_acc[15] ? 14'd0 :
                     (w_acc > 16'sd8192) ? cfcc_pkg::ANG_OCTANT[13:0] : w_acc[13:0];
    assign w_a     = r_swapped ? (cfcc_pkg::ANG_QUARTER[14:0] - 15'(w_acc_c)) : 15'(w_acc_c);

    always_comb begin
        if (!r_xneg && !r_yneg) begin
            w_ang = 17'(w_a);
        end else if (r_xneg && !r_yneg) begin
            w_ang = cfcc_pkg::ANG_HALF - 17'(w_a);
        end else if (r_xneg) begin
            w_ang = cfcc_pkg::ANG_HALF + 17'(w_a);
        end else begin
            w_ang = cfcc_pkg::ANG_FULL - 17'(w_a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.angle) begin
            r_angle <= w_ang[15:0];
        end
    end

    // distance tests and sector index
    assign w_d         = (|r_dsum[SW-1:cfcc_pkg::D_W]) ? '1 : r_dsum[cfcc_pkg::D_W-1:0];
    assign w_ring_hit  = !((w_d < 64'(r_rmin2)) || (w_d > 64'(r_rmax2)));
    assign w_inner_hit = ({w_d, 32'd0} < 96'(r_tt));

    assign w_n   = (r_sec_cnt == '0) ? 7'd1 :
                   (7'(r_sec_cnt) > 7'(MAX_SECTORS)) ? 7'(MAX_SECTORS) : 7'(r_sec_cnt);
    assign w_sp  = 23'(r_angle) * 23'(w_n);
    assign w_s   = w_sp[22:16];
    assign w_s_c = (w_s > (w_n - 7'd1)) ? (w_n - 7'd1) : w_s;
    assign w_idx = w_s_c[SIW-1:0];

    assign w_verdict = (r_inner > r_ilim) ? cfcc_pkg::VERDICT_INNER :
                       (r_occ < r_min_sec) ? cfcc_pkg::VERDICT_COVERAGE :
                       cfcc_pkg::VERDICT_PASS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner     <= '0;
            r_marks     <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                if (w_inner_hit && (r_inner != '1)) begin
                    r_inner <= r_inner + 1'b1;
                end
                if (w_ring_hit) begin
                    r_marks[w_idx] <= 1'b1;
                    if (!r_marks[w_idx] && (r_occ != '1)) begin
                        r_occ <= r_occ + 1'b1;
                    end
                end
            end
            if (i_cmd.emit) begin
                r_inner     <= '0;
                r_marks     <= '0;
                r_occ       <= '0;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_inner   <= r_inner;
            r_out_occ     <= r_occ;
            r_out_verdict <= w_verdict;
        end
    end

    assign o_stat.last     = r_last;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_inner         = r_out_inner;
    assign o_occ           = r_out_occ;
    assign o_verdict       = r_out_verdict;

endmodule

// ===== hw/rtl/circle_fit_coverage_check_unit.sv =====
`timescale 1ns / 1ps
// Top level of the circle fit coverage check unit: controller plus datapath.
// Depends on cfcc_pkg, cfcc_pt_if, cfcc_res_if, cfcc_ctrl and cfcc_datapath.
//
// Checks a stream of points against a fitted circle: each point is counted as inner
// when it lies strictly inside radius * inner_proportion, and marks an angular sector
// when it lies on the ring radius +/- ring_width. The point flagged last_point yields
// one result (inner count, occupied sectors, verdict) and clears the section state.
// One point is handled at a time, in order: a prepare step, 16 iterations of the CORDIC
// angle unit (the single shared multiplier forms its eight products alongside), an angle
// step and an update step. A last point then passes an emit step that loads the result
// register, waiting there until the previous result has been taken. The result register
// lets the next point in while a result waits. Configuration is written through a plain
// indexed write port; the user must write it only while no point is in progress, as the
// block does not enforce this. After reset all registers read zero except sector_count,
// which reads 16.
module circle_fit_coverage_check_unit #(
    parameter int MAX_SECTORS = 32,
    parameter int COORD_BITS  = 24
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    cfcc_pt_if.sink                                              i_pt,
    cfcc_res_if.source                                           o_res,
    input  logic                                                 i_cfg_we,
    input  logic [cfcc_pkg::CFG_IDX_W-1:0]                       i_cfg_idx,
    input  logic [((COORD_BITS > 23) ? COORD_BITS : 23)-1:0]     i_cfg_data
);

    localparam int CFG_W = (COORD_BITS > 23) ? COORD_BITS : 23;

    cfcc_pkg::t_cmd  w_cmd;
    cfcc_pkg::t_stat w_stat;
    logic            w_in_ready;

    cfcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pt.valid),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    cfcc_datapath #(
        .MAX_SECTORS (MAX_SECTORS),
        .COORD_BITS  (COORD_BITS),
        .CFG_W       (CFG_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_px        (i_pt.point_x),
        .i_py        (i_pt.point_y),
        .i_last      (i_pt.last_point),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_inner     (o_res.inner_points),
        .o_occ       (o_res.occupied_sectors),
        .o_verdict   (o_res.verdict)
    );

    assign i_pt.ready = w_in_ready;

endmodule

// ===== hw/rtl/cfcc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the circle fit coverage check unit, bound to the top level.
// Depends on the top level's channel ports only.
module cfcc_checker #(
    parameter int MAX_SECTORS = 32
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_inner_points,
    input logic [5:0]  i_occupied_sectors,
    input logic [1:0]  i_verdict
);

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("point taken while previous point still in progress");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_inner_points)
            && $stable(i_occupied_sectors) && $stable(i_verdict)))
        else $error("stalled result changed or dropped");

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ({1'b0, i_occupied_sectors} <= 7'(MAX_SECTORS)))
        else $error("occupied sector count above sector capacity");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("channels not in idle state after reset");

endmodule

bind circle_fit_coverage_check_unit cfcc_checker #(
    .MAX_SECTORS (MAX_SECTORS)
) u_cfcc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_pt.valid),
    .i_in_ready         (i_pt.ready),
    .i_out_valid        (o_res.valid),
    .i_out_ready        (o_res.ready),
    .i_inner_points     (o_res.inner_points),
    .i_occupied_sectors (o_res.occupied_sectors),
    .i_verdict          (o_res.verdict)
);
